// ----- rtl/rte_pkg.sv -----
// ----------------------------------------------------------------------------
// RTF text escaper package
// Shared types, character constants and the control-word lookup tables.
// ----------------------------------------------------------------------------
package rte_pkg;

  localparam int ITEM_MAX = 11;
  localparam int LEN_W    = 4;
  localparam int BYTE_W   = 7;

  // ASCII bytes
  localparam logic [BYTE_W-1:0] CH_BSLASH = 7'h5c;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 7'h7b;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 7'h7d;
  localparam logic [BYTE_W-1:0] CH_U      = 7'h75;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 7'h20;

  // Code units with control words
  localparam logic [15:0] CU_TAB    = 16'h0009;
  localparam logic [15:0] CU_NBSP   = 16'h00a0;
  localparam logic [15:0] CU_SHY    = 16'h00ad;
  localparam logic [15:0] CU_MIDDOT = 16'h00b7;
  localparam logic [15:0] CU_NBHYPH = 16'h2011;
  localparam logic [15:0] CU_ENSP   = 16'h2002;
  localparam logic [15:0] CU_EMSP   = 16'h2003;
  localparam logic [15:0] CU_QMSP   = 16'h2004;
  localparam logic [15:0] CU_ZWNJ   = 16'h200c;
  localparam logic [15:0] CU_ZWJ    = 16'h200d;
  localparam logic [15:0] CU_LRM    = 16'h200e;
  localparam logic [15:0] CU_RLM    = 16'h200f;
  localparam logic [15:0] CU_ENDASH = 16'h2013;
  localparam logic [15:0] CU_EMDASH = 16'h2014;
  localparam logic [15:0] CU_LQUOTE = 16'h2018;
  localparam logic [15:0] CU_RQUOTE = 16'h2019;
  localparam logic [15:0] CU_LDQ    = 16'h201c;
  localparam logic [15:0] CU_RDQ    = 16'h201d;
  localparam logic [15:0] CU_BULLET = 16'h2022;

  localparam logic [15:0] CU_PRINT_LO = 16'd32;
  localparam logic [15:0] CU_PRINT_HI = 16'd126;
  localparam logic [15:0] CU_DEL      = 16'd127;

  typedef enum logic [1:0] {CLS_PLAIN, CLS_ESC, CLS_WORD, CLS_UNI} rte_cls_t;

  typedef enum logic [4:0] {
    W_TAB, W_NBSP, W_SHY, W_MIDDOT, W_NBHYPH, W_ENSP, W_EMSP, W_QMSP,
    W_ZWNJ, W_ZWJ, W_LRM, W_RLM, W_ENDASH, W_EMDASH, W_LQUOTE, W_RQUOTE,
    W_LDQ, W_RDQ, W_BULLET
  } rte_word_t;

  typedef struct packed {
    logic      hit;
    rte_word_t idx;
  } rte_hit_t;

  typedef struct packed {
    logic [ITEM_MAX-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]                len;
  } rte_item_t;

  // stage 2 -> 3
  typedef struct packed {
    rte_cls_t    cls;
    rte_word_t   widx;
    logic [2:0]  nd;
    logic [15:0] code;
    logic [6:0]  hi;
  } rte_s2_t;

  // stage 3 -> 4
  typedef struct packed {
    rte_cls_t          cls;
    rte_word_t         widx;
    logic [2:0]        nd;
    logic [BYTE_W-1:0] c7;
    logic [2:0]        d4;
    logic [3:0]        d3;
    logic [9:0]        lo;
  } rte_s3_t;

  // stage 4 -> 5
  typedef struct packed {
    rte_cls_t          cls;
    rte_word_t         widx;
    logic [2:0]        nd;
    logic [BYTE_W-1:0] c7;
    logic [2:0]        d4;
    logic [3:0]        d3;
    logic [3:0]        d2;
    logic [6:0]        r2;
  } rte_s4_t;

  function automatic rte_hit_t rte_word_lookup(input logic [15:0] c);
    rte_hit_t h;
    h.hit = 1'b1;
    h.idx = W_TAB;
    case (c)
      CU_TAB:    h.idx = W_TAB;
      CU_NBSP:   h.idx = W_NBSP;
      CU_SHY:    h.idx = W_SHY;
      CU_MIDDOT: h.idx = W_MIDDOT;
      CU_NBHYPH: h.idx = W_NBHYPH;
      CU_ENSP:   h.idx = W_ENSP;
      CU_EMSP:   h.idx = W_EMSP;
      CU_QMSP:   h.idx = W_QMSP;
      CU_ZWNJ:   h.idx = W_ZWNJ;
      CU_ZWJ:    h.idx = W_ZWJ;
      CU_LRM:    h.idx = W_LRM;
      CU_RLM:    h.idx = W_RLM;
      CU_ENDASH: h.idx = W_ENDASH;
      CU_EMDASH: h.idx = W_EMDASH;
      CU_LQUOTE: h.idx = W_LQUOTE;
      CU_RQUOTE: h.idx = W_RQUOTE;
      CU_LDQ:    h.idx = W_LDQ;
      CU_RDQ:    h.idx = W_RDQ;
      CU_BULLET: h.idx = W_BULLET;
      default:   h.hit = 1'b0;
    endcase
    return h;
  endfunction

  // Control word text, first character in byte 0.
  function automatic rte_item_t rte_word_item(input rte_word_t idx);
    logic [8*ITEM_MAX-1:0] s;
    logic [LEN_W-1:0]      n;
    rte_item_t             it;
    case (idx)
      W_TAB:    begin s = "\\tab ";        n = 4'd5;  end
      W_NBSP:   begin s = "\\~";           n = 4'd2;  end
      W_SHY:    begin s = "\\-";           n = 4'd2;  end
      W_MIDDOT: begin s = "\\|";           n = 4'd2;  end
      W_NBHYPH: begin s = "\\_";           n = 4'd2;  end
      W_ENSP:   begin s = "\\enspace ";    n = 4'd9;  end
      W_EMSP:   begin s = "\\emspace ";    n = 4'd9;  end
      W_QMSP:   begin s = "\\qmspace ";    n = 4'd9;  end
      W_ZWNJ:   begin s = "\\zwnj ";       n = 4'd6;  end
      W_ZWJ:    begin s = "\\zwj ";        n = 4'd5;  end
      W_LRM:    begin s = "\\ltrmark ";    n = 4'd9;  end
      W_RLM:    begin s = "\\rtrmark ";    n = 4'd9;  end
      W_ENDASH: begin s = "\\endash ";     n = 4'd8;  end
      W_EMDASH: begin s = "\\emdash ";     n = 4'd8;  end
      W_LQUOTE: begin s = "\\lquote ";     n = 4'd8;  end
      W_RQUOTE: begin s = "\\rquote ";     n = 4'd8;  end
      W_LDQ:    begin s = "\\ldblquote ";  n = 4'd11; end
      W_RDQ:    begin s = "\\rdblquote ";  n = 4'd11; end
      W_BULLET: begin s = "\\bullet ";     n = 4'd8;  end
      default:  begin s = '0;              n = 4'd1;  end
    endcase
    // left-align the literal
    s = s << (8 * (ITEM_MAX - int'(n)));
    for (int k = 0; k < ITEM_MAX; k++) begin
      it.bytes[k] = s[8*(ITEM_MAX-1-k) +: BYTE_W];
    end
    it.len = n;
    return it;
  endfunction

  // Tens digit of a value below 70.
  function automatic logic [2:0] rte_tens(input logic [6:0] v);
    logic [2:0] t;
    if (v >= 7'd60)      t = 3'd6;
    else if (v >= 7'd50) t = 3'd5;
    else if (v >= 7'd40) t = 3'd4;
    else if (v >= 7'd30) t = 3'd3;
    else if (v >= 7'd20) t = 3'd2;
    else if (v >= 7'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  function automatic logic [BYTE_W-1:0] rte_digit(input logic [3:0] d);
    return {3'b011, d};
  endfunction

endpackage

// ----- rtl/rte_front.sv -----
// ----------------------------------------------------------------------------
// RTF escaper front end
// Input register, then classification and the thousands split of the code.
// ----------------------------------------------------------------------------
module rte_front
  import rte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_vld,
  input  logic [15:0] up_code,
  output logic        up_rdy,
  output logic        dn_vld,
  output rte_s2_t     dn_data,
  input  logic        dn_rdy
);

  logic        s1_vld_r, s1_vld_nxt;
  logic [15:0] s1_code_r;
  logic        s2_vld_r, s2_vld_nxt;
  rte_s2_t     s2_r, s2_nxt;
  logic        rdy1, rdy2;
  rte_hit_t    hit;
  logic [26:0] hi_prod;

  assign rdy2   = !s2_vld_r || dn_rdy;
  assign rdy1   = !s1_vld_r || rdy2;
  assign up_rdy = rdy1;

  assign s1_vld_nxt = rdy1 ? up_vld : s1_vld_r;
  assign s2_vld_nxt = rdy2 ? s1_vld_r : s2_vld_r;

  // code / 1000 as (code >> 3) * 8389 >> 20, exact below 65536
  assign hi_prod = {14'd0, s1_code_r[15:3]} * 27'd8389;

  always_comb begin
    hit          = rte_word_lookup(s1_code_r);
    s2_nxt.code  = s1_code_r;
    s2_nxt.hi    = hi_prod[26:20];
    s2_nxt.widx  = hit.idx;
    if (s1_code_r == {9'd0, CH_BSLASH} || s1_code_r == {9'd0, CH_LBRACE} ||
        s1_code_r == {9'd0, CH_RBRACE}) begin
      s2_nxt.cls = CLS_ESC;
    end else if (s1_code_r >= CU_PRINT_LO && s1_code_r <= CU_PRINT_HI) begin
      s2_nxt.cls = CLS_PLAIN;
    end else if (hit.hit) begin
      s2_nxt.cls = CLS_WORD;
    end else if (s1_code_r >= CU_DEL) begin
      s2_nxt.cls = CLS_UNI;
    end else begin
      s2_nxt.cls = CLS_PLAIN;
    end
    if (s1_code_r >= 16'd10000)     s2_nxt.nd = 3'd5;
    else if (s1_code_r >= 16'd1000) s2_nxt.nd = 3'd4;
    else                            s2_nxt.nd = 3'd3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_vld) begin
      s1_code_r <= up_code;
    end
    if (rdy2 && s1_vld_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign dn_vld  = s2_vld_r;
  assign dn_data = s2_r;

endmodule

// ----- rtl/rte_digits.sv -----
// ----------------------------------------------------------------------------
// RTF escaper decimal digits
// Two stages that split the code into its upper decimal digits.
// ----------------------------------------------------------------------------
module rte_digits
  import rte_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_vld,
  input  rte_s2_t up_data,
  output logic    up_rdy,
  output logic    dn_vld,
  output rte_s4_t dn_data,
  input  logic    dn_rdy
);

  logic        s3_vld_r, s3_vld_nxt;
  rte_s3_t     s3_r, s3_nxt;
  logic        s4_vld_r, s4_vld_nxt;
  rte_s4_t     s4_r, s4_nxt;
  logic        rdy3, rdy4;
  logic [16:0] hi1000;
  logic [6:0]  d4x10;
  logic [15:0] d2_prod;
  logic [9:0]  d2x100;

  assign rdy4   = !s4_vld_r || dn_rdy;
  assign rdy3   = !s3_vld_r || rdy4;
  assign up_rdy = rdy3;

  assign s3_vld_nxt = rdy3 ? up_vld : s3_vld_r;
  assign s4_vld_nxt = rdy4 ? s3_vld_r : s4_vld_r;

  // 1000 = 1024 - 16 - 8
  assign hi1000 = {up_data.hi, 10'd0} - {6'd0, up_data.hi, 4'd0}
                - {7'd0, up_data.hi, 3'd0};

  always_comb begin
    s3_nxt.cls  = up_data.cls;
    s3_nxt.widx = up_data.widx;
    s3_nxt.nd   = up_data.nd;
    s3_nxt.c7   = up_data.code[BYTE_W-1:0];
    s3_nxt.lo   = up_data.code[9:0] - hi1000[9:0];
    s3_nxt.d4   = rte_tens(up_data.hi);
    d4x10       = {1'b0, s3_nxt.d4, 3'd0} + {3'd0, s3_nxt.d4, 1'b0};
    s3_nxt.d3   = 4'(up_data.hi - d4x10);
  end

  // lo / 100 as lo * 41 >> 12, exact below 1000
  assign d2_prod = {6'd0, s3_r.lo} * 16'd41;

  always_comb begin
    s4_nxt.cls  = s3_r.cls;
    s4_nxt.widx = s3_r.widx;
    s4_nxt.nd   = s3_r.nd;
    s4_nxt.c7   = s3_r.c7;
    s4_nxt.d4   = s3_r.d4;
    s4_nxt.d3   = s3_r.d3;
    s4_nxt.d2   = d2_prod[15:12];
    d2x100      = {s4_nxt.d2, 6'd0} + {1'b0, s4_nxt.d2, 5'd0}
                + {4'd0, s4_nxt.d2, 2'd0};
    s4_nxt.r2   = 7'(s3_r.lo - d2x100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s3_vld_nxt;
      s4_vld_r <= s4_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && up_vld) begin
      s3_r <= s3_nxt;
    end
    if (rdy4 && s3_vld_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign dn_vld  = s4_vld_r;
  assign dn_data = s4_r;

endmodule

// ----- rtl/rte_assemble.sv -----
// ----------------------------------------------------------------------------
// RTF escaper byte assembly
// Last two digits, then the full byte run and its length for one code unit.
// ----------------------------------------------------------------------------
module rte_assemble
  import rte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_vld,
  input  rte_s4_t   up_data,
  output logic      up_rdy,
  output logic      dn_vld,
  output rte_item_t dn_item,
  input  logic      dn_rdy
);

  logic        s5_vld_r, s5_vld_nxt;
  rte_item_t   s5_r, s5_nxt;
  logic        rdy5;
  logic [14:0] d1_prod;
  logic [3:0]  d1, d0;
  logic [6:0]  d1x10;

  assign rdy5       = !s5_vld_r || dn_rdy;
  assign up_rdy     = rdy5;
  assign s5_vld_nxt = rdy5 ? up_vld : s5_vld_r;

  // r2 / 10 as r2 * 205 >> 11, exact below 100
  assign d1_prod = {8'd0, up_data.r2} * 15'd205;
  assign d1      = d1_prod[14:11];
  assign d1x10   = {d1, 3'd0} + {2'd0, d1, 1'b0};
  assign d0      = 4'(up_data.r2 - d1x10);

  always_comb begin
    s5_nxt = '0;
    case (up_data.cls)
      CLS_PLAIN: begin
        s5_nxt.bytes[0] = up_data.c7;
        s5_nxt.len      = 4'd1;
      end
      CLS_ESC: begin
        s5_nxt.bytes[0] = CH_BSLASH;
        s5_nxt.bytes[1] = up_data.c7;
        s5_nxt.len      = 4'd2;
      end
      CLS_WORD: begin
        s5_nxt = rte_word_item(up_data.widx);
      end
      CLS_UNI: begin
        s5_nxt.bytes[0] = CH_BSLASH;
        s5_nxt.bytes[1] = CH_U;
        // drop leading zero digits
        case (up_data.nd)
          3'd5: begin
            s5_nxt.bytes[2] = rte_digit({1'b0, up_data.d4});
            s5_nxt.bytes[3] = rte_digit(up_data.d3);
            s5_nxt.bytes[4] = rte_digit(up_data.d2);
            s5_nxt.bytes[5] = rte_digit(d1);
            s5_nxt.bytes[6] = rte_digit(d0);
            s5_nxt.bytes[7] = CH_SPACE;
            s5_nxt.len      = 4'd8;
          end
          3'd4: begin
            s5_nxt.bytes[2] = rte_digit(up_data.d3);
            s5_nxt.bytes[3] = rte_digit(up_data.d2);
            s5_nxt.bytes[4] = rte_digit(d1);
            s5_nxt.bytes[5] = rte_digit(d0);
            s5_nxt.bytes[6] = CH_SPACE;
            s5_nxt.len      = 4'd7;
          end
          default: begin
            s5_nxt.bytes[2] = rte_digit(up_data.d2);
            s5_nxt.bytes[3] = rte_digit(d1);
            s5_nxt.bytes[4] = rte_digit(d0);
            s5_nxt.bytes[5] = CH_SPACE;
            s5_nxt.len      = 4'd6;
          end
        endcase
      end
      default: begin
        s5_nxt.bytes[0] = up_data.c7;
        s5_nxt.len      = 4'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s5_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && up_vld) begin
      s5_r <= s5_nxt;
    end
  end

  assign dn_vld  = s5_vld_r;
  assign dn_item = s5_r;

endmodule

// ----- rtl/rte_serializer.sv -----
// ----------------------------------------------------------------------------
// RTF escaper serializer
// Holds one byte run and sends it out a word per cycle unless stalled, marking the last.
// ----------------------------------------------------------------------------
module rte_serializer
  import rte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_vld,
  input  rte_item_t         up_item,
  output logic              up_rdy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_byte
);

  logic             vld_r, vld_nxt;
  rte_item_t        item_r;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             fire, last, load;

  assign last   = (idx_r == item_r.len - 4'd1);
  assign fire   = vld_r && !out_stall;
  assign up_rdy = !vld_r || (fire && last);
  assign load   = up_rdy && up_vld;

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = '0;
    end else if (fire && last) begin
      vld_nxt = 1'b0;
    end else if (fire) begin
      // advance within the run
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= up_item;
    end
  end

  assign out_valid     = vld_r;
  assign out_byte      = item_r.bytes[idx_r];
  assign out_last_byte = last;

endmodule

// ----- rtl/rtf_text_escaper.sv -----
// ----------------------------------------------------------------------------
// RTF text escaper
// One UTF-16 code unit in, its RTF text form out as 1 to 11 ASCII words.
// ----------------------------------------------------------------------------
// Each code unit passes the input register, stages 2 to 5 and the serializer register.
// Throughput: one code unit per cycle while each yields a single word and the output
// is not stalled; a unit of n words (n = 1..11) holds the output serializer until its
// last word is sent, which then sets the input rate, backed by the five-stage pipeline.
// Reset (rst_n low, synchronous) clears all valid bits; data registers keep state.
module rtf_text_escaper
  import rte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_code_unit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_byte
);

  logic      in_rdy;
  logic      f_vld, f_rdy;
  rte_s2_t   f_data;
  logic      g_vld, g_rdy;
  rte_s4_t   g_data;
  logic      a_vld, a_rdy;
  rte_item_t a_item;

  assign in_stall = !in_rdy;

  rte_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_valid),
    .up_code (in_code_unit),
    .up_rdy  (in_rdy),
    .dn_vld  (f_vld),
    .dn_data (f_data),
    .dn_rdy  (f_rdy)
  );

  rte_digits u_digits (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (f_vld),
    .up_data (f_data),
    .up_rdy  (f_rdy),
    .dn_vld  (g_vld),
    .dn_data (g_data),
    .dn_rdy  (g_rdy)
  );

  rte_assemble u_assemble (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (g_vld),
    .up_data (g_data),
    .up_rdy  (g_rdy),
    .dn_vld  (a_vld),
    .dn_item (a_item),
    .dn_rdy  (a_rdy)
  );

  rte_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_vld        (a_vld),
    .up_item       (a_item),
    .up_rdy        (a_rdy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

// ----- rtl/rte_checker.sv -----
// ----------------------------------------------------------------------------
// RTF escaper port checker
// Port-level properties of the escaper, bound to the top level.
// ----------------------------------------------------------------------------
module rte_checker
  import rte_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_last_byte
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_byte))
    else $error("stalled output word changed");

  // a run is never cut short
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_byte |=> out_valid)
    else $error("byte run broken before last word");

  // a space only ever ends a run
  a_space_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_byte |-> out_byte != CH_SPACE)
    else $error("space inside a byte run");

endmodule

bind rtf_text_escaper rte_checker u_rte_checker (.*);

// ----- tb/sv/rte_escape_checker.sv -----
// ----------------------------------------------------------------------------
// RTF escape checker
// Watches both channels of the RTF text escaper, expands each accepted code
// unit into its escaped byte run and compares every output word against it.
// ----------------------------------------------------------------------------
module rte_escape_checker
  import rte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [15:0]       in_code_unit,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [BYTE_W-1:0] out_byte,
  input  logic              out_last_byte,
  output int                n_mismatch,
  output int                n_pending,
  output int                n_units,
  output int                n_bytes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } rtf_byte_t;

  rtf_byte_t escaped_bytes_q[$];
  rtf_byte_t want;

  function automatic string control_word(input logic [15:0] cu);
    case (cu)
      CU_TAB:    return "\\tab ";
      CU_NBSP:   return "\\~";
      CU_SHY:    return "\\-";
      CU_MIDDOT: return "\\|";
      CU_NBHYPH: return "\\_";
      CU_ENSP:   return "\\enspace ";
      CU_EMSP:   return "\\emspace ";
      CU_QMSP:   return "\\qmspace ";
      CU_ZWNJ:   return "\\zwnj ";
      CU_ZWJ:    return "\\zwj ";
      CU_LRM:    return "\\ltrmark ";
      CU_RLM:    return "\\rtrmark ";
      CU_ENDASH: return "\\endash ";
      CU_EMDASH: return "\\emdash ";
      CU_LQUOTE: return "\\lquote ";
      CU_RQUOTE: return "\\rquote ";
      CU_LDQ:    return "\\ldblquote ";
      CU_RDQ:    return "\\rdblquote ";
      CU_BULLET: return "\\bullet ";
      default:   return "";
    endcase
  endfunction

  // Expand one code unit into the byte run the escaper should emit.
  function automatic void predict_escape(input logic [15:0] cu);
    logic [BYTE_W-1:0] run[$];
    string             w;
    w = control_word(cu);
    if (cu == {9'd0, CH_BSLASH} || cu == {9'd0, CH_LBRACE} || cu == {9'd0, CH_RBRACE}) begin
      run.push_back(CH_BSLASH);
      run.push_back(cu[BYTE_W-1:0]);
    end else if (cu >= CU_PRINT_LO && cu <= CU_PRINT_HI) begin
      run.push_back(cu[BYTE_W-1:0]);
    end else if (w.len() != 0) begin
      for (int k = 0; k < w.len(); k++) run.push_back(BYTE_W'(w[k]));
    end else if (cu >= CU_DEL) begin
      w = $sformatf("\\u%0d ", cu);
      for (int k = 0; k < w.len(); k++) run.push_back(BYTE_W'(w[k]));
    end else begin
      // control codes other than tab go through untouched
      run.push_back(cu[BYTE_W-1:0]);
    end
    foreach (run[k]) escaped_bytes_q.push_back({run[k], 1'(k == run.size() - 1)});
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      n_mismatch = 0;
      n_pending  = 0;
      n_units    = 0;
      n_bytes    = 0;
      escaped_bytes_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        n_bytes++;
        if (escaped_bytes_q.size() == 0) begin
          n_mismatch++;
          $display("%0t: unexpected word: expected none, got byte %h last %b",
                   $time, out_byte, out_last_byte);
        end else begin
          want = escaped_bytes_q.pop_front();
          if (out_byte !== want.ch) begin
            n_mismatch++;
            $display("%0t: out_byte mismatch: expected %h, got %h",
                     $time, want.ch, out_byte);
          end
          if (out_last_byte !== want.last) begin
            n_mismatch++;
            $display("%0t: out_last_byte mismatch: expected %b, got %b",
                     $time, want.last, out_last_byte);
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_units++;
        predict_escape(in_code_unit);
      end
      n_pending = escaped_bytes_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// RTF text escaper testbench
// Drives directed and random UTF-16 code units with random idle cycles on
// both channels; the escape checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_top
  import rte_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 102;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 20;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [15:0]       in_code_unit  = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last_byte;
  logic              no_idle       = 1'b0;

  int n_mismatch;
  int n_pending;
  int n_units;
  int n_bytes;
  int idle_cycles = 0;
  int n_directed  = 0;

  logic [15:0] word_codes[19] = '{
    CU_TAB, CU_NBSP, CU_SHY, CU_MIDDOT, CU_NBHYPH, CU_ENSP, CU_EMSP, CU_QMSP,
    CU_ZWNJ, CU_ZWJ, CU_LRM, CU_RLM, CU_ENDASH, CU_EMDASH, CU_LQUOTE,
    CU_RQUOTE, CU_LDQ, CU_RDQ, CU_BULLET
  };
  logic [15:0] esc_codes[3] = '{{9'd0, CH_BSLASH}, {9'd0, CH_LBRACE}, {9'd0, CH_RBRACE}};
  logic [15:0] edge_codes[7] = '{16'd127, 16'd128, 16'd999, 16'd1000, 16'd9999,
                                 16'd10000, 16'd65535};
  logic [15:0] odd_codes[7] = '{16'h0000, 16'h001f, 16'h0020, 16'h007e,
                                16'h005c, 16'h007f, 16'hffff};

  always #5 clk = ~clk;

  rtf_text_escaper u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_unit  (in_code_unit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  rte_escape_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_unit  (in_code_unit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .n_mismatch    (n_mismatch),
    .n_pending     (n_pending),
    .n_units       (n_units),
    .n_bytes       (n_bytes)
  );

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 7);
  end

  // Stop when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_code(input logic [15:0] cu);
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_unit <= cu;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] random_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      return 16'($urandom_range(32, 126));
    else if (r < 48) return esc_codes[$urandom_range(0, 2)];
    else if (r < 53) return 16'($urandom_range(0, 31));
    else if (r < 68) return word_codes[$urandom_range(0, 18)];
    else if (r < 73) return edge_codes[$urandom_range(0, 6)];
    else if (r < 78) return 16'($urandom_range(127, 999));
    else             return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (odd_codes[k]) begin
      send_code(odd_codes[k]);
      n_directed++;
    end
    send_code(esc_codes[1]);
    send_code(esc_codes[2]);
    n_directed += 2;
    foreach (word_codes[k]) begin
      send_code(word_codes[k]);
      n_directed++;
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      // hold both sides busy through the middle stretch
      if (i == 50) no_idle <= 1'b1;
      if (i == 90) no_idle <= 1'b0;
      send_code(random_code());
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("Sent %0d code units (%0d directed), checked %0d output bytes",
             n_units, n_directed, n_bytes);
    $display("Covered escapes, control words, control codes and decimal forms");
    if (n_mismatch == 0 && n_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
